// ===== design/fltw_pkg.sv =====
// ============================================================================
// fltw_pkg: shared types and microcode for the four-level page table walker
// Holds the control word layout, the step and code enumerations, the control
// store contents and the table entry address helper.
// ============================================================================
`timescale 1ns / 1ps

package fltw_pkg;

    // Operation codes carried by the func field.
    typedef enum logic [1:0] {
        FN_WRITE     = 2'd0,
        FN_TRANSLATE = 2'd1,
        FN_UNMAP     = 2'd2,
        FN_NONE      = 2'd3
    } t_func;

    // Microprogram step addresses.
    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_WR        = 4'd1,
        S_RD4       = 4'd2,
        S_RD3       = 4'd3,
        S_RD2       = 4'd4,
        S_CHK2      = 4'd5,
        S_LEAF      = 4'd6,
        S_HUGE      = 4'd7,
        S_UNMAP_CLR = 4'd8,
        S_MISS      = 4'd9,
        S_NOP       = 4'd10,
        S_CLR       = 4'd11
    } t_step;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_NONE,
        C_DISPATCH,
        C_HUGE,
        C_UNMAP,
        C_CLR_MORE
    } t_cond;

    // Store operation.
    typedef enum logic [1:0] {
        M_NONE,
        M_READ,
        M_WRITE
    } t_mem;

    // Store address source.
    typedef enum logic [2:0] {
        A_ROOT,
        A_ENTRY,
        A_WORD,
        A_SLOT,
        A_CLR
    } t_asel;

    // Virtual address index field used for a table fetch.
    typedef enum logic [1:0] {
        I_L4,
        I_L3,
        I_L2,
        I_L1
    } t_isel;

    // Result source.
    typedef enum logic [1:0] {
        R_ZERO,
        R_MISS,
        R_HUGE,
        R_LEAF
    } t_rsel;

    // One control word of the microprogram.
    typedef struct packed {
        t_cond  cond;
        t_step  target;
        t_step  next;
        logic   chk_present;
        t_mem   mem_op;
        t_asel  asel;
        t_isel  isel;
        logic   wzero;
        logic   done;
        t_rsel  rsel;
        logic   load_in;
        logic   clr_inc;
    } t_ctl;

    // Sequencer to datapath.
    typedef struct packed {
        t_ctl   ctl;
        logic   taken;
    } t_fltw_seq;

    // Datapath to sequencer.
    typedef struct packed {
        logic   start;
        t_func  in_func;
        logic   present;
        logic   huge;
        logic   unmap;
        logic   clr_more;
    } t_fltw_stat;

    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;
    localparam int IDX_W       = 9;
    localparam int PAGE_SHIFT  = 12;
    localparam int HUGE_SHIFT  = 21;

    // Word number of a table entry: the base has its low 12 bits cleared and
    // the index times eight stays below 4096, so no carry reaches the base.
    function automatic logic [60:0] fltw_entry_word(input logic [63:0] base,
                                                    input logic [IDX_W-1:0] idx);
        return {base[63:PAGE_SHIFT], idx};
    endfunction

    // Control store.
    function automatic t_ctl fltw_ucode(input t_step step);
        t_ctl c;
        c = '0;
        c.next = S_IDLE;
        c.target = S_IDLE;
        unique case (step)
            S_IDLE: begin
                c.cond    = C_DISPATCH;
                c.load_in = 1'b1;
            end
            S_WR: begin
                c.mem_op = M_WRITE;
                c.asel   = A_WORD;
                c.done   = 1'b1;
                c.rsel   = R_ZERO;
            end
            S_RD4: begin
                c.mem_op = M_READ;
                c.asel   = A_ROOT;
                c.isel   = I_L4;
                c.next   = S_RD3;
            end
            S_RD3: begin
                c.chk_present = 1'b1;
                c.mem_op      = M_READ;
                c.asel        = A_ENTRY;
                c.isel        = I_L3;
                c.next        = S_RD2;
            end
            S_RD2: begin
                c.chk_present = 1'b1;
                c.mem_op      = M_READ;
                c.asel        = A_ENTRY;
                c.isel        = I_L2;
                c.next        = S_CHK2;
            end
            S_CHK2: begin
                c.chk_present = 1'b1;
                c.cond        = C_HUGE;
                c.target      = S_HUGE;
                c.mem_op      = M_READ;
                c.asel        = A_ENTRY;
                c.isel        = I_L1;
                c.next        = S_LEAF;
            end
            S_LEAF: begin
                c.cond   = C_UNMAP;
                c.target = S_UNMAP_CLR;
                c.done   = 1'b1;
                c.rsel   = R_LEAF;
            end
            S_HUGE: begin
                c.cond   = C_UNMAP;
                c.target = S_UNMAP_CLR;
                c.done   = 1'b1;
                c.rsel   = R_HUGE;
            end
            S_UNMAP_CLR: begin
                c.mem_op = M_WRITE;
                c.asel   = A_SLOT;
                c.wzero  = 1'b1;
                c.done   = 1'b1;
                c.rsel   = R_ZERO;
            end
            S_MISS: begin
                c.done = 1'b1;
                c.rsel = R_MISS;
            end
            S_NOP: begin
                c.done = 1'b1;
                c.rsel = R_ZERO;
            end
            S_CLR: begin
                c.mem_op  = M_WRITE;
                c.asel    = A_CLR;
                c.wzero   = 1'b1;
                c.clr_inc = 1'b1;
                c.cond    = C_CLR_MORE;
                c.target  = S_CLR;
            end
            default: begin
                c.next = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== design/fltw_useq.sv =====
// ============================================================================
// fltw_useq: microprogram sequencer
// Holds the step counter, reads the control store and resolves the present
// check and the conditional jump of each control word.
// ============================================================================
`timescale 1ns / 1ps

module fltw_useq import fltw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fltw_stat i_stat,
    output t_fltw_seq  o_seq,
    output logic       o_busy,
    output logic       o_clearing
);

    t_step r_step;
    t_step n_step;
    t_step w_dispatch;
    t_ctl  w_ctl;
    logic  w_cond;
    logic  w_miss;

    // Control store read.
    assign w_ctl = fltw_ucode(r_step);

    // Entry point for each operation.
    always_comb begin
        unique case (i_stat.in_func) inside
            FN_TRANSLATE, FN_UNMAP: w_dispatch = S_RD4;
            FN_WRITE:               w_dispatch = S_WR;
            FN_NONE:                w_dispatch = S_NOP;
            default:                w_dispatch = S_NOP;
        endcase
    end

    // Branch condition decode.
    always_comb begin
        unique case (w_ctl.cond)
            C_NONE:     w_cond = 1'b0;
            C_DISPATCH: w_cond = i_stat.start;
            C_HUGE:     w_cond = i_stat.huge;
            C_UNMAP:    w_cond = i_stat.unmap;
            C_CLR_MORE: w_cond = i_stat.clr_more;
            default:    w_cond = 1'b0;
        endcase
    end

    // Next step: a non-present entry wins over the coded branch.
    always_comb begin
        w_miss = w_ctl.chk_present && !i_stat.present;
        if (w_miss) begin
            n_step = S_MISS;
        end else if (w_cond) begin
            n_step = (w_ctl.cond == C_DISPATCH) ? w_dispatch : w_ctl.target;
        end else begin
            n_step = w_ctl.next;
        end
    end

    // Step counter; reset starts the store clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_seq.ctl   = w_ctl;
    assign o_seq.taken = w_miss || w_cond;
    assign o_busy      = (r_step != S_IDLE);
    assign o_clearing  = (r_step == S_CLR);

endmodule

// ===== design/fltw_dpath.sv =====
// ============================================================================
// fltw_dpath: walker datapath
// Holds the physical word store, the root register, the captured request,
// the fetched entry, the store address mux and the result register.
// ============================================================================
`timescale 1ns / 1ps

module fltw_dpath import fltw_pkg::*; #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_func,
    input  logic [47:0] i_address,
    input  logic [63:0] i_write_data,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    input  t_fltw_seq   i_seq,
    output t_fltw_stat  o_stat,
    output logic        o_result_valid,
    output logic [63:0] o_phys_result,
    output logic        o_not_mapped
);

    localparam int ADDR_W = $clog2(STORE_WORDS);

    logic [63:0]       r_mem [STORE_WORDS];
    logic [63:0]       r_rdata;
    logic [ADDR_W-1:0] r_slot;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [47:0]       r_root;
    t_func             r_func;
    logic [47:0]       r_address;
    logic [63:0]       r_write_data;
    logic              r_valid;
    logic [63:0]       r_result;
    logic              r_miss;

    logic [ADDR_W-1:0] w_addr;
    logic [IDX_W-1:0]  w_idx;
    logic [47:0]       w_word_byte;
    logic [60:0]       w_root_word;
    logic [60:0]       w_entry_word;
    logic              w_rd_en;
    logic              w_wr_en;
    logic [63:0]       w_wdata;
    logic              w_done;

    // Index field of the virtual address for this level.
    always_comb begin
        unique case (i_seq.ctl.isel)
            I_L4:    w_idx = r_address[47:39];
            I_L3:    w_idx = r_address[38:30];
            I_L2:    w_idx = r_address[29:21];
            I_L1:    w_idx = r_address[20:12];
            default: w_idx = r_address[47:39];
        endcase
    end

    assign w_root_word  = fltw_entry_word({16'd0, r_root}, w_idx);
    assign w_entry_word = fltw_entry_word(r_rdata, w_idx);
    assign w_word_byte  = r_address >> 3;

    // Store address source; every word number wraps to the store size.
    always_comb begin
        unique case (i_seq.ctl.asel)
            A_ROOT:  w_addr = w_root_word[ADDR_W-1:0];
            A_ENTRY: w_addr = w_entry_word[ADDR_W-1:0];
            A_WORD:  w_addr = w_word_byte[ADDR_W-1:0];
            A_SLOT:  w_addr = r_slot;
            A_CLR:   w_addr = r_clr_cnt;
            default: w_addr = r_slot;
        endcase
    end

    // A taken branch cancels the read and the result of its step.
    assign w_rd_en = (i_seq.ctl.mem_op == M_READ) && !i_seq.taken;
    assign w_wr_en = (i_seq.ctl.mem_op == M_WRITE);
    assign w_done  = i_seq.ctl.done && !i_seq.taken;
    assign w_wdata = i_seq.ctl.wzero ? 64'd0 : r_write_data;

    // Physical word store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_addr];
            r_slot  <= w_addr;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_seq.ctl.clr_inc) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Root table register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    // Request capture on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_seq.ctl.load_in) begin
            r_func       <= t_func'(i_func);
            r_address    <= i_address;
            r_write_data <= i_write_data;
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            unique case (i_seq.ctl.rsel)
                R_ZERO: begin
                    r_result <= 64'd0;
                    r_miss   <= 1'b0;
                end
                R_MISS: begin
                    r_result <= 64'd0;
                    r_miss   <= 1'b1;
                end
                R_HUGE: begin
                    r_result <= {r_rdata[63:HUGE_SHIFT], r_address[HUGE_SHIFT-1:0]};
                    r_miss   <= 1'b0;
                end
                R_LEAF: begin
                    r_result <= r_rdata[PRESENT_BIT]
                              ? {r_rdata[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} : 64'd0;
                    r_miss   <= !r_rdata[PRESENT_BIT];
                end
                default: begin
                    r_result <= 64'd0;
                    r_miss   <= 1'b0;
                end
            endcase
        end
    end

    // Status toward the sequencer.
    assign o_stat.start    = i_accept;
    assign o_stat.in_func  = t_func'(i_func);
    assign o_stat.present  = r_rdata[PRESENT_BIT];
    assign o_stat.huge     = r_rdata[HUGE_BIT];
    assign o_stat.unmap    = (r_func == FN_UNMAP);
    assign o_stat.clr_more = (r_clr_cnt != {ADDR_W{1'b1}});

    assign o_result_valid = r_valid;
    assign o_phys_result  = r_result;
    assign o_not_mapped   = r_miss;

endmodule

// ===== design/four_level_page_table_walker_unit.sv =====
// ============================================================================
// four_level_page_table_walker_unit: microcoded four-level page table walker
// Runs write, translate and unmap commands; a walk may stop at an absent entry,
// and an unused code returns a zero result. One transaction at a time; the
// next is accepted at the edge that takes the result, and throughput is bound
// by dependent reads of the single-port word store.
// After reset the block clears every word of the store with busy high; the
// result strobe lasts one cycle and cannot be stalled.
// ============================================================================
`timescale 1ns / 1ps

module four_level_page_table_walker_unit import fltw_pkg::*; #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [47:0] i_address,
    input  logic [63:0] i_write_data,
    input  logic        i_cfg_we,
    input  logic [47:0] i_cfg_wdata,
    output logic        o_result_valid,
    output logic [63:0] o_phys_result,
    output logic        o_not_mapped
);

    t_fltw_seq  w_seq;
    t_fltw_stat w_stat;
    logic       w_accept;
    logic       w_clearing;

    assign w_accept = start && !busy;

    // Sequencer with control store.
    fltw_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_seq      (w_seq),
        .o_busy     (busy),
        .o_clearing (w_clearing)
    );

    // Store, registers and result datapath.
    fltw_dpath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_func         (i_func),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_seq          (w_seq),
        .o_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_phys_result  (o_phys_result),
        .o_not_mapped   (o_not_mapped)
    );

`ifndef SYNTH
    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("block not busy after an accepted transaction");

    // A miss always reports a zero value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_not_mapped) |-> (o_phys_result == 64'd0))
        else $error("miss reported with a nonzero value");

    // Results of two transactions never sit in adjacent cycles.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // No result appears while the store is being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clearing && $past(w_clearing)) |-> !o_result_valid)
        else $error("result strobe during the clearing pass");
`endif

endmodule

// ===== tb/sv/tb_four_level_page_table_walker_unit.sv =====
// ============================================================================
// tb_four_level_page_table_walker_unit: self-checking bench for the walker
// Builds page tables in the word store through write transactions, then
// translates and unmaps through them. Each accepted command runs through a
// behavioral walker and the expected result is checked, field by field,
// against the result strobe. The table root is changed between phases.
// ============================================================================
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_unit;
    import fltw_pkg::*;

    localparam int STORE_WORDS = 4096;
    localparam int PAGES       = STORE_WORDS / 512;
    localparam int PAGE_BITS   = $clog2(PAGES);

    // One command as the block sees it, and the result it must produce.
    typedef struct {
        t_func       func;
        logic [47:0] address;
        logic [63:0] data;
    } t_walk_cmd;

    typedef struct {
        logic [63:0] phys;
        logic        miss;
    } t_walk_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic [47:0] i_address = '0;
    logic [63:0] i_write_data = '0;
    logic        i_cfg_we = 1'b0;
    logic [47:0] i_cfg_wdata = '0;
    logic        o_result_valid;
    logic [63:0] o_phys_result;
    logic        o_not_mapped;

    // Mirror of the physical store and the root register.
    logic [63:0]  store_model [STORE_WORDS];
    logic [47:0]  root_model;

    t_walk_cmd    cmd_backlog [$];
    t_walk_result walk_results_due [$];
    t_walk_cmd    cur_cmd;
    t_walk_result due;
    bit           holding = 1'b0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           send_idle_pct = 0;

    int n_queued = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int n_write = 0;
    int n_hit = 0;
    int n_huge = 0;
    int n_miss = 0;
    int n_clear = 0;

    four_level_page_table_walker_unit #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_phys_result  (o_phys_result),
        .o_not_mapped   (o_not_mapped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up long after the slowest legal run would have finished.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = rand64();
        return r[47:0];
    endfunction

    // Store word selected by a physical byte address.
    function automatic int unsigned word_of(input logic [63:0] byte_addr);
        return 32'((byte_addr >> 3) % STORE_WORDS);
    endfunction

    function automatic int unsigned table_slot(input logic [63:0] base,
                                               input logic [8:0] idx);
        return word_of((base & ~64'hFFF) + {idx, 3'b000});
    endfunction

    // Table entry pointing at a store page; the bits above the page number
    // are random so that the word index has to wrap.
    function automatic logic [63:0] table_entry(input int unsigned page, input logic present,
                                                input logic huge_flag);
        logic [63:0] e;
        e = rand64();
        e[12 +: PAGE_BITS] = page[PAGE_BITS-1:0];
        e[0] = present;
        e[7] = huge_flag;
        return e;
    endfunction

    // Byte address of one entry of a table page, with random upper bits.
    function automatic logic [47:0] slot_addr(input int unsigned page, input logic [8:0] idx);
        logic [47:0] a;
        a = rand48();
        a[12 +: PAGE_BITS] = page[PAGE_BITS-1:0];
        a[11:3] = idx;
        return a;
    endfunction

    task automatic push_cmd(input t_func func, input logic [47:0] address,
                            input logic [63:0] data);
        t_walk_cmd c;
        c.func = func;
        c.address = address;
        c.data = data;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    // Behavioral walk: updates the store mirror and queues the result.
    task automatic predict_walk(input t_walk_cmd cmd);
        t_walk_result r;
        logic [63:0]  ent;
        logic [8:0]   ix [4];
        int unsigned  slot;
        bit           stop;
        r.phys = '0;
        r.miss = 1'b0;
        ix[3] = cmd.address[47:39];
        ix[2] = cmd.address[38:30];
        ix[1] = cmd.address[29:21];
        ix[0] = cmd.address[20:12];
        case (cmd.func)
            FN_WRITE: begin
                store_model[word_of({16'b0, cmd.address})] = cmd.data;
                n_write++;
            end
            FN_TRANSLATE, FN_UNMAP: begin
                ent = {16'b0, root_model};
                stop = 1'b0;
                for (int lvl = 3; lvl >= 0 && !stop; lvl--) begin
                    slot = table_slot(ent, ix[lvl]);
                    ent = store_model[slot];
                    if (lvl > 0 && !ent[0]) begin
                        r.miss = 1'b1;
                        stop = 1'b1;
                        n_miss++;
                    end else if (lvl == 1 && ent[7]) begin
                        // A huge second-level entry ends the walk.
                        stop = 1'b1;
                        if (cmd.func == FN_TRANSLATE) begin
                            r.phys = (ent & ~64'h1FFFFF) + {43'b0, cmd.address[20:0]};
                            n_huge++;
                        end else begin
                            store_model[slot] = '0;
                            n_clear++;
                        end
                    end else if (lvl == 0) begin
                        if (cmd.func == FN_UNMAP) begin
                            store_model[slot] = '0;
                            n_clear++;
                        end else if (ent[0]) begin
                            r.phys = ent & ~64'hFFF;
                            n_hit++;
                        end else begin
                            r.miss = 1'b1;
                            n_miss++;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        walk_results_due.push_back(r);
    endtask

    task automatic flag_mismatch(input string msg);
        if (n_mismatch < 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    // Driver: presents the backlog with random gaps and no-gap bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            holding = 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                predict_walk(cur_cmd);
                holding = 1'b0;
            end
            if (holding) begin
                // Keep the command up until the block takes it.
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                if (burst_left == 0 && $urandom_range(99) < send_idle_pct) begin
                    gap_left = $urandom_range(5);
                    start <= 1'b0;
                end else begin
                    cur_cmd = cmd_backlog.pop_front();
                    holding = 1'b1;
                    start <= 1'b1;
                    i_func <= cur_cmd.func;
                    i_address <= cur_cmd.address;
                    i_write_data <= cur_cmd.data;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else if ($urandom_range(9) == 0)
                        burst_left = $urandom_range(24, 4);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (walk_results_due.size() == 0) begin
                flag_mismatch($sformatf("result with none outstanding: phys_result %h not_mapped %b",
                                        o_phys_result, o_not_mapped));
            end else begin
                due = walk_results_due.pop_front();
                n_checked++;
                if (o_phys_result !== due.phys)
                    flag_mismatch($sformatf("phys_result expected %h got %h",
                                            due.phys, o_phys_result));
                if (o_not_mapped !== due.miss)
                    flag_mismatch($sformatf("not_mapped expected %b got %b",
                                            due.miss, o_not_mapped));
            end
        end
    end

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || holding || walk_results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Root update; only called with nothing in flight.
    task automatic write_root(input logic [47:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        root_model = value;
    endtask

    task automatic queue_noise();
        push_cmd(t_func'($urandom_range(3)), rand48(), rand64());
    endtask

    // Extremes and the corner cases of the walk, with the root at its reset value.
    task automatic queue_directed();
        logic [47:0] va_top;
        va_top = '1;
        push_cmd(FN_TRANSLATE, 48'h0, rand64());
        push_cmd(FN_TRANSLATE, va_top, '0);
        push_cmd(FN_UNMAP, va_top, '1);
        push_cmd(FN_NONE, va_top, '1);
        // Top word of the store becomes an all-ones entry.
        push_cmd(FN_WRITE, va_top, '1);
        // Build the walk for the top virtual address one level at a time.
        push_cmd(FN_WRITE, slot_addr(0, 9'h1FF), table_entry(1, 1'b1, 1'b0));
        push_cmd(FN_TRANSLATE, va_top, '0);
        // The huge bit above the second level must be ignored.
        push_cmd(FN_WRITE, slot_addr(1, 9'h1FF), table_entry(2, 1'b1, 1'b1));
        push_cmd(FN_TRANSLATE, va_top, '0);
        push_cmd(FN_WRITE, slot_addr(2, 9'h1FF), table_entry(3, 1'b1, 1'b0));
        push_cmd(FN_TRANSLATE, va_top, '0);
        // Unmap of an absent leaf still clears it and reports it as mapped.
        push_cmd(FN_UNMAP, va_top, '0);
        push_cmd(FN_WRITE, slot_addr(3, 9'h1FF), '1);
        push_cmd(FN_TRANSLATE, va_top, '0);
        push_cmd(FN_TRANSLATE, 48'hFFFF_FFFF_F000, '0);
        push_cmd(FN_UNMAP, va_top, '0);
        push_cmd(FN_TRANSLATE, va_top, '0);
        // All-ones second-level entry: a huge page at the top of the space.
        push_cmd(FN_WRITE, slot_addr(2, 9'h1FF), '1);
        push_cmd(FN_TRANSLATE, va_top, '0);
        push_cmd(FN_TRANSLATE, 48'hFFFF_FFE0_0000, '0);
        push_cmd(FN_UNMAP, va_top, '0);
        push_cmd(FN_TRANSLATE, va_top, '0);
        // Every bit set except present at the top level.
        push_cmd(FN_WRITE, slot_addr(0, 9'h1FF), 64'hFFFF_FFFF_FFFF_FFFE);
        push_cmd(FN_TRANSLATE, va_top, '0);
    endtask

    // A table chain for a random virtual address, mostly complete, then
    // translations through it and sometimes an unmap.
    task automatic queue_walk_scenario();
        logic [47:0] va;
        logic [47:0] alt;
        logic [8:0]  ix [4];
        int unsigned pg [4];
        int          depth;
        logic        huge_map;
        logic [63:0] ent;
        va = rand48();
        ix[3] = va[47:39];
        ix[2] = va[38:30];
        ix[1] = va[29:21];
        ix[0] = va[20:12];
        pg[3] = (root_model >> 12) % PAGES;
        for (int l = 0; l < 3; l++)
            pg[l] = $urandom_range(PAGES - 1);
        depth = ($urandom_range(9) < 8) ? 4 : $urandom_range(3);
        huge_map = ($urandom_range(2) == 0);
        for (int l = 3; l >= 0; l--) begin
            if (3 - l < depth) begin
                if (l == 0)
                    ent = rand64() | 64'h1;
                else if (l == 1)
                    ent = table_entry(pg[l-1], 1'b1, huge_map);
                else
                    ent = table_entry(pg[l-1], 1'b1, 1'($urandom_range(1)));
                push_cmd(FN_WRITE, slot_addr(pg[l], ix[l]), ent);
            end else if (3 - l == depth && $urandom_range(1)) begin
                push_cmd(FN_WRITE, slot_addr(pg[l], ix[l]), rand64() & ~64'h1);
            end
            if ($urandom_range(19) == 0)
                queue_noise();
        end
        push_cmd(FN_TRANSLATE, va, rand64());
        alt = rand48();
        alt[47:21] = va[47:21];
        if ($urandom_range(1))
            alt[20:12] = va[20:12];
        if ($urandom_range(1))
            push_cmd(FN_TRANSLATE, alt, rand64());
        if ($urandom_range(4) < 2) begin
            push_cmd(FN_UNMAP, $urandom_range(1) ? va : alt, rand64());
            push_cmd(FN_TRANSLATE, va, rand64());
        end
    endtask

    // Sequence: reset, directed cases, then random phases under new roots.
    initial begin
        logic [47:0] root_pick [4];
        int          idle_pick [4];
        int          phase_start;
        int          chunk_start;
        root_pick[0] = '1;
        root_pick[1] = rand48();
        root_pick[2] = rand48();
        root_pick[3] = '0;
        idle_pick[0] = 0;
        idle_pick[1] = 87;
        idle_pick[2] = 32;
        idle_pick[3] = 0;
        foreach (store_model[i])
            store_model[i] = '0;
        root_model = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 0;
        queue_directed();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            // A pause between phases; an unmap's clearing write lands before its result.
            repeat (8) @(posedge i_clk);
            write_root(root_pick[p]);
            send_idle_pct = idle_pick[p];
            phase_start = n_queued;
            while (n_queued - phase_start < 150) begin
                chunk_start = n_queued;
                while (n_queued - chunk_start < 50) begin
                    if ($urandom_range(9) == 0)
                        queue_noise();
                    else
                        queue_walk_scenario();
                end
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (walk_results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", walk_results_due.size()));

        $display("Checked %0d transactions under five root settings: %0d writes, %0d leaf hits,",
                 n_checked, n_write, n_hit);
        $display("%0d huge-page hits, %0d walks stopped at an absent entry, %0d entries unmapped.",
                 n_huge, n_miss, n_clear);
        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
